// File: src/vrt_pkg.sv
// ----------------------------------------------------------------------------
// vrt_pkg: shared types and constants of the voxel ray traversal block
// grid geometry, fixed-point widths and the sequencer state type
// ----------------------------------------------------------------------------
package vrt_pkg;

  localparam int GRID_BITS = 5;
  localparam int FRAC_BITS = 16;
  localparam int T_BITS    = 16;
  localparam int IDX_BITS  = 3 * GRID_BITS;
  localparam int GRID_N    = 1 << GRID_BITS;
  localparam int CELLS     = 1 << IDX_BITS;

  // field widths
  localparam int ORG_W  = 21;
  localparam int DIR_W  = 18;
  localparam int MAG_W  = DIR_W;
  localparam int DIST_W = 7;
  localparam int LEN_W  = MAG_W + DIST_W;
  localparam int NUM_W  = FRAC_BITS + T_BITS + 1;
  // t values: saturation 10000000 << 16 needs 40 bits, plus growth
  localparam int TM_W   = 42;
  localparam int TD_W   = 40;
  localparam int VOX_W  = ORG_W - FRAC_BITS + 2;

  localparam logic [TD_W-1:0] T_SAT = TD_W'(64'd10000000 << T_BITS);
  localparam logic [TM_W-1:0] T_ONE = TM_W'(64'd1 << T_BITS);
  localparam logic [DIST_W-1:0] DIST_RESET = DIST_W'(8);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_TMAX,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } vrt_state_t;

endpackage

// File: src/voxel_ray_traversal_top.sv
// ----------------------------------------------------------------------------
// voxel_ray_traversal_top: occupancy grid with 3D DDA ray casting
//
// usage: pulse start with an item while busy is low. opcode write sets one
// voxel of the 32x32x32 grid; opcode cast walks a ray from origin along
// dir * max_distance and reports the first solid voxel with the face normal
// of the last axis stepped, or a miss. every item gives exactly one result
// beat on out_valid, held for one cycle; the receiver cannot stall it.
// a write goes to ST_DONE, which registers its result beat.
// a cast runs the three reciprocal divisions (one shared restoring
// divider: length latch, 33 quotient bits one a cycle, store), then tMax
// for each axis, then per voxel visited a grid memory read, then compare
// and step; the voxel loop through the single read port sets the walk
// rate.
// at reset the grid memory is swept to air, one voxel a cycle over all
// 32768 voxels, with busy high; cfg writes are taken during the sweep.
// max_distance resets to 8 and is written through cfg_we/cfg_wdata.
// ----------------------------------------------------------------------------
module voxel_ray_traversal_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_opcode,
  input  logic [4:0]                   in_cell_x,
  input  logic [4:0]                   in_cell_y,
  input  logic [4:0]                   in_cell_z,
  input  logic                         in_solid,
  input  logic [vrt_pkg::ORG_W-1:0]    in_origin_x,
  input  logic [vrt_pkg::ORG_W-1:0]    in_origin_y,
  input  logic [vrt_pkg::ORG_W-1:0]    in_origin_z,
  input  logic signed [vrt_pkg::DIR_W-1:0] in_dir_x,
  input  logic signed [vrt_pkg::DIR_W-1:0] in_dir_y,
  input  logic signed [vrt_pkg::DIR_W-1:0] in_dir_z,
  input  logic                         cfg_we,
  input  logic [vrt_pkg::DIST_W-1:0]   cfg_wdata,
  output logic                         out_valid,
  output logic                         out_hit,
  output logic [4:0]                   out_hit_x,
  output logic [4:0]                   out_hit_y,
  output logic [4:0]                   out_hit_z,
  output logic signed [1:0]            out_normal_x,
  output logic signed [1:0]            out_normal_y,
  output logic signed [1:0]            out_normal_z
);
  import vrt_pkg::*;

  vrt_state_t state_r, state_nxt;

  // grid memory
  logic                grid_mem [CELLS];
  logic                mem_we;
  logic [IDX_BITS-1:0] mem_waddr, mem_raddr;
  logic                mem_wdata, mem_rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) grid_mem[mem_waddr] <= mem_wdata;
    mem_rdata_r <= grid_mem[mem_raddr];
  end

  // configuration
  logic [DIST_W-1:0] dist_r;
  always_ff @(posedge clk) begin
    if (!rst_n) dist_r <= DIST_RESET;
    else if (cfg_we) dist_r <= cfg_wdata;
  end

  // per-axis registers
  logic [ORG_W-1:0]        org_r   [3];
  logic [DIR_W-1:0]        dir_r   [3];
  logic [TD_W-1:0]         td_r    [3];
  logic [TM_W-1:0]         tm_r    [3];
  logic signed [VOX_W-1:0] vox_r   [3];
  logic signed [1:0]       d_r     [3];
  logic [1:0]              axis_r;
  logic [1:0]              last_r;
  logic                    stepped_r;
  logic [IDX_BITS:0]       clr_r;
  logic [5:0]              bit_r;

  // divider registers: remainder and quotient
  logic [LEN_W:0]   rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [LEN_W-1:0] len_r;

  // result registers
  logic       ov_r, oh_r;
  logic [4:0] ox_r, oy_r, oz_r;
  logic signed [1:0] onx_r, ony_r, onz_r;

  assign busy = (state_r != ST_IDLE);
  assign out_valid = ov_r;
  assign out_hit = oh_r;
  assign out_hit_x = ox_r;
  assign out_hit_y = oy_r;
  assign out_hit_z = oz_r;
  assign out_normal_x = onx_r;
  assign out_normal_y = ony_r;
  assign out_normal_z = onz_r;

  // axis magnitude and sign of the selected axis
  logic             neg_sel;
  logic [MAG_W-1:0] mag_sel;
  logic [LEN_W-1:0] len_sel;
  always_comb begin
    neg_sel = dir_r[axis_r][DIR_W-1];
    mag_sel = neg_sel ? (MAG_W'(0) - dir_r[axis_r]) : dir_r[axis_r];
    len_sel = LEN_W'(mag_sel) * LEN_W'(dist_r);
  end

  // restoring divider step: numerator is 2^(FRAC+T), its top bit fed in first
  logic [LEN_W:0]   rem_sh;
  logic             q_bit;
  logic [LEN_W:0]   rem_new;
  always_comb begin
    rem_sh  = {rem_r[LEN_W-1:0], (bit_r == 6'd1)};
    q_bit   = (rem_sh >= {1'b0, len_r});
    rem_new = q_bit ? (rem_sh - {1'b0, len_r}) : rem_sh;
  end

  // tMax product of the selected axis
  logic [FRAC_BITS:0]          g_sel;
  logic [TD_W+FRAC_BITS:0]     tm_prod;
  always_comb begin
    if (d_r[axis_r] == 2'sd1)
      g_sel = (FRAC_BITS+1)'(1 << FRAC_BITS) - (FRAC_BITS+1)'(org_r[axis_r][FRAC_BITS-1:0]);
    else
      g_sel = (FRAC_BITS+1)'(org_r[axis_r][FRAC_BITS-1:0]);
    tm_prod = (TD_W+FRAC_BITS+1)'(td_r[axis_r]) * (TD_W+FRAC_BITS+1)'(g_sel);
  end

  // walk decisions
  logic       outside;
  logic [1:0] a_sel;
  logic [TM_W-1:0] tm_step;
  logic       all_past;
  always_comb begin
    outside = 1'b0;
    for (int k = 0; k < 3; k++)
      if (vox_r[k] < 0 || vox_r[k] >= VOX_W'(GRID_N)) outside = 1'b1;
    if (tm_r[0] < tm_r[1] && tm_r[0] < tm_r[2]) a_sel = 2'd0;
    else if (tm_r[1] < tm_r[2])                 a_sel = 2'd1;
    else                                        a_sel = 2'd2;
    tm_step = tm_r[a_sel] + TM_W'(td_r[a_sel]);
    all_past = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (k == int'(a_sel)) begin
        if (!(tm_step > T_ONE)) all_past = 1'b0;
      end else if (!(tm_r[k] > T_ONE)) all_past = 1'b0;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

  // memory port control and next state
  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_waddr = {in_cell_z, in_cell_y, in_cell_x};
    mem_wdata = in_solid;
    mem_raddr = {vox_r[2][GRID_BITS-1:0], vox_r[1][GRID_BITS-1:0],
                 vox_r[0][GRID_BITS-1:0]};
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r[IDX_BITS-1:0];
        mem_wdata = 1'b0;
        if (clr_r == (IDX_BITS+1)'(CELLS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          if (in_opcode == OP_WRITE) begin
            mem_we    = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (bit_r == 6'(NUM_W + 1) && axis_r == 2'd2) state_nxt = ST_TMAX;
      end
      ST_TMAX: begin
        if (axis_r == 2'd2) state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = outside ? ST_DONE : ST_CHECK;
      end
      ST_CHECK: begin
        if (mem_rdata_r || all_past) state_nxt = ST_DONE;
        else                         state_nxt = ST_READ;
      end
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      ov_r <= 1'b0;
      case (state_r)
        ST_CLEAR: clr_r <= clr_r + 1'b1;
        ST_IDLE: begin
          oh_r  <= 1'b0;
          ox_r  <= '0; oy_r <= '0; oz_r <= '0;
          onx_r <= '0; ony_r <= '0; onz_r <= '0;
          if (start) begin
            org_r[0] <= in_origin_x; org_r[1] <= in_origin_y; org_r[2] <= in_origin_z;
            dir_r[0] <= in_dir_x;    dir_r[1] <= in_dir_y;    dir_r[2] <= in_dir_z;
            axis_r    <= 2'd0;
            bit_r     <= '0;
            stepped_r <= 1'b0;
          end
        end
        ST_DIV: begin
          // bit 0: latch length and sign; then NUM_W quotient bits; then store
          if (bit_r == 6'd0) begin
            len_r <= len_sel;
            rem_r <= '0;
            quo_r <= '0;
            if (mag_sel != '0 && dist_r != '0) d_r[axis_r] <= neg_sel ? -2'sd1 : 2'sd1;
            else                               d_r[axis_r] <= 2'sd0;
            bit_r <= bit_r + 1'b1;
          end else if (bit_r <= 6'(NUM_W)) begin
            rem_r <= rem_new;
            quo_r <= {quo_r[NUM_W-2:0], q_bit};
            bit_r <= bit_r + 1'b1;
          end else begin
            if (d_r[axis_r] == 2'sd0 || TD_W'(quo_r) >= T_SAT) td_r[axis_r] <= T_SAT;
            else td_r[axis_r] <= TD_W'(quo_r);
            vox_r[axis_r] <= VOX_W'(org_r[axis_r][ORG_W-1:FRAC_BITS]);
            bit_r <= '0;
            axis_r <= (axis_r == 2'd2) ? 2'd0 : axis_r + 1'b1;
          end
        end
        ST_TMAX: begin
          tm_r[axis_r] <= TM_W'(tm_prod >> FRAC_BITS);
          axis_r <= (axis_r == 2'd2) ? 2'd0 : axis_r + 1'b1;
        end
        ST_READ: ;
        ST_CHECK: begin
          if (mem_rdata_r) begin
            oh_r <= 1'b1;
            ox_r <= vox_r[0][4:0]; oy_r <= vox_r[1][4:0]; oz_r <= vox_r[2][4:0];
            if (stepped_r) begin
              if (last_r == 2'd0) onx_r <= -d_r[0];
              if (last_r == 2'd1) ony_r <= -d_r[1];
              if (last_r == 2'd2) onz_r <= -d_r[2];
            end
          end else begin
            vox_r[a_sel] <= vox_r[a_sel] + VOX_W'(d_r[a_sel]);
            tm_r[a_sel]  <= tm_step;
            last_r       <= a_sel;
            stepped_r    <= 1'b1;
          end
        end
        ST_DONE: ov_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // checks
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result beat longer than one cycle");
  a_beat_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result beat while busy");
  a_done_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |=> out_valid) else $error("missing result beat");
  a_no_miss_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_hit_x == 5'd0 && out_normal_x == 2'sd0))
    else $error("miss with nonzero fields");

endmodule
